// ===== rtl/core/crfc_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the frame checker.
// No dependencies; every other file imports this package.
package crfc_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 17;
    localparam int LEN_W  = 16;
    localparam int CRC_W  = 16;
    localparam int STAT_W = 2;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [BYTE_W-1:0] START_BYTE     = 8'h7E;
    localparam logic [POS_W-1:0]  HDR_BYTES      = 17'd5;
    localparam logic [POS_W-1:0]  CRC_BYTES      = 17'd2;
    localparam logic [CRC_W-1:0]  CRC_INIT       = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY_REFL  = 16'hA001;

    // Register index, taken from paddr[2].
    localparam logic REG_STATION_ID  = 1'b0;
    localparam logic REG_REQUEST_CMD = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK  = 2'd0,
        ST_HDR = 2'd1,
        ST_CRC = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'b01,
        PH_ACTIVE = 2'b10
    } phase_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [POS_W-1:0] frame_size;
    } result_t;

    // One byte of CRC-16/MODBUS, reflected, eight shift steps.
    function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                     input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/crfc_rx_if.sv =====
// Receive channel: one frame byte per beat with a frame-start mark.
// Depends on crfc_pkg.
interface crfc_rx_if
    import crfc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    logic              frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ===== rtl/core/crfc_res_if.sv =====
// Result channel: one checked-frame verdict per beat.
// Depends on crfc_pkg.
interface crfc_res_if
    import crfc_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  frame_size;

    modport source (output valid, output status, output frame_size, input ready);
    modport sink   (input valid, input status, input frame_size, output ready);
endinterface

// ===== rtl/core/crfc_apb_regs.sv =====
// APB configuration registers: expected station id and request command.
// Depends on crfc_pkg.
module crfc_apb_regs
    import crfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic [BYTE_W-1:0] station_id,
    output logic [BYTE_W-1:0] request_cmd
);

    logic [BYTE_W-1:0] station_id_reg, station_id_next;
    logic [BYTE_W-1:0] request_cmd_reg, request_cmd_next;
    logic              wr_en;

    // Byte lanes below the word address are ignored.
    assign wr_en = psel && penable && pwrite;

    always_comb
    begin
        station_id_next  = station_id_reg;
        request_cmd_next = request_cmd_reg;
        if (wr_en)
        begin
            unique case (paddr[2])
                REG_STATION_ID:  station_id_next  = pwdata[BYTE_W-1:0];
                REG_REQUEST_CMD: request_cmd_next = pwdata[BYTE_W-1:0];
                default:         station_id_next  = station_id_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            station_id_reg  <= '0;
            request_cmd_reg <= '0;
        end
        else
        begin
            station_id_reg  <= station_id_next;
            request_cmd_reg <= request_cmd_next;
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_STATION_ID:  prdata = {{(APB_DW-BYTE_W){1'b0}}, station_id_reg};
            REG_REQUEST_CMD: prdata = {{(APB_DW-BYTE_W){1'b0}}, request_cmd_reg};
            default:         prdata = '0;
        endcase
    end

    assign station_id  = station_id_reg;
    assign request_cmd = request_cmd_reg;

endmodule

// ===== rtl/core/crfc_parser.sv =====
// Frame state and per-byte decision: header checks, length capture, CRC update,
// final CRC compare. Depends on crfc_pkg.
module crfc_parser
    import crfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              frame_start,
    input  logic [BYTE_W-1:0] station_id,
    input  logic [BYTE_W-1:0] request_cmd,
    output result_t           result
);

    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CRC_W-1:0]  crc_reg, crc_next;
    logic [BYTE_W-1:0] crc_lo_reg, crc_lo_next;

    logic              active;
    logic [POS_W-1:0]  pos_cur;
    logic [LEN_W-1:0]  len_cur;
    logic [CRC_W-1:0]  crc_cur;
    logic [BYTE_W-1:0] crc_lo_cur;
    logic [POS_W-1:0]  body_end;
    logic [CRC_W-1:0]  crc_upd;
    logic              hdr_bad;

    // A frame start restarts the checker with this byte as byte zero.
    assign active     = frame_start || (phase_reg == PH_ACTIVE);
    assign pos_cur    = frame_start ? '0 : pos_reg;
    assign len_cur    = frame_start ? '0 : len_reg;
    assign crc_cur    = frame_start ? CRC_INIT : crc_reg;
    assign crc_lo_cur = frame_start ? '0 : crc_lo_reg;
    assign body_end   = HDR_BYTES + {1'b0, len_cur};
    assign crc_upd    = crc16_byte(crc_cur, rx_byte);

    always_comb
    begin
        hdr_bad = 1'b0;
        unique case (pos_cur[2:0])
            3'd0:    hdr_bad = (rx_byte != START_BYTE);
            3'd1:    hdr_bad = (rx_byte != station_id);
            3'd2:    hdr_bad = (rx_byte != (request_cmd + 8'd1));
            default: hdr_bad = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next        = phase_reg;
        pos_next          = pos_reg;
        len_next          = len_reg;
        crc_next          = crc_reg;
        crc_lo_next       = crc_lo_reg;
        result.valid      = 1'b0;
        result.status     = ST_OK;
        result.frame_size = '0;

        if (step && active)
        begin
            phase_next  = PH_ACTIVE;
            pos_next    = pos_cur + 17'd1;
            len_next    = len_cur;
            crc_next    = crc_cur;
            crc_lo_next = crc_lo_cur;

            priority if (pos_cur < HDR_BYTES)
            begin
                crc_next = crc_upd;
                if (pos_cur[2:0] == 3'd3)
                begin
                    len_next = {rx_byte, 8'h00};
                end
                else if (pos_cur[2:0] == 3'd4)
                begin
                    len_next = {len_cur[LEN_W-1:BYTE_W], rx_byte};
                end
                if (hdr_bad)
                begin
                    phase_next    = PH_IDLE;
                    result.valid  = 1'b1;
                    result.status = ST_HDR;
                end
            end
            else if (pos_cur < body_end)
            begin
                crc_next = crc_upd;
            end
            else if (pos_cur == body_end)
            begin
                crc_lo_next = rx_byte;
            end
            else
            begin
                phase_next   = PH_IDLE;
                result.valid = 1'b1;
                if ((crc_lo_cur == crc_cur[7:0]) && (rx_byte == crc_cur[15:8]))
                begin
                    result.status     = ST_OK;
                    result.frame_size = body_end + CRC_BYTES;
                end
                else
                begin
                    result.status = ST_CRC;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            len_reg    <= '0;
            crc_reg    <= CRC_INIT;
            crc_lo_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            len_reg    <= len_next;
            crc_reg    <= crc_next;
            crc_lo_reg <= crc_lo_next;
        end
    end

endmodule

// ===== rtl/core/crc_response_frame_checker.sv =====
// Top level of the response frame checker: input register, parser, result register.
// Depends on crfc_pkg, crfc_rx_if, crfc_res_if, crfc_apb_regs and crfc_parser.
//
//   Channel   Kind          Payload                      Beat
//   rx_in     valid/ready   rx_byte[7:0], frame_start    one received byte
//   res_out   valid/ready   status[1:0], frame_size[16:0] one frame verdict
//   APB       psel/penable  paddr[2:0], pwdata, prdata   one register access
//
// One byte is taken every cycle unless a held verdict stalls res_out. The parser handles
// a byte from the input register once the result register can take the verdict it causes.
// The CRC update and the position compare in the parser form each byte step's logic path.
// rst_n clears the frame state, the APB registers and both stage valid flags.
// When res_out stalls with a verdict held, the input register keeps one more byte,
// then rx_in.ready drops until the verdict is taken.
module crc_response_frame_checker
    import crfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    crfc_rx_if.sink           rx_in,
    crfc_res_if.source        res_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [BYTE_W-1:0] station_id;
    logic [BYTE_W-1:0] request_cmd;
    result_t           result;

    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_start_reg;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg;
    logic [POS_W-1:0]  out_size_reg;

    logic              rx_accept;
    logic              advance;
    logic              step;

    assign pready = 1'b1;

    crfc_apb_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .station_id  (station_id),
        .request_cmd (request_cmd)
    );

    // The parser moves whenever the result register can take its verdict.
    assign advance      = !out_valid_reg || res_out.ready;
    assign step         = s1_valid_reg && advance;
    assign rx_in.ready  = !s1_valid_reg || advance;
    assign rx_accept    = rx_in.valid && rx_in.ready;

    crfc_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .rx_byte     (s1_byte_reg),
        .frame_start (s1_start_reg),
        .station_id  (station_id),
        .request_cmd (request_cmd),
        .result      (result)
    );

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (rx_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (step)
        begin
            s1_valid_next = 1'b0;
        end
    end

    assign out_valid_next = advance ? (step && result.valid) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_accept)
        begin
            s1_byte_reg  <= rx_in.rx_byte;
            s1_start_reg <= rx_in.frame_start;
        end
        if (step && result.valid)
        begin
            out_status_reg <= result.status;
            out_size_reg   <= result.frame_size;
        end
    end

    assign res_out.valid      = out_valid_reg;
    assign res_out.status     = out_status_reg;
    assign res_out.frame_size = out_size_reg;

    // A good frame is at least header plus CRC long; an error carries no size.
    a_ok_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_OK)) |-> (out_size_reg >= 17'd7))
        else $error("ok verdict with a frame size below the minimum");

    a_err_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg != ST_OK)) |-> (out_size_reg == '0))
        else $error("error verdict with a nonzero frame size");

    // A verdict can only appear when the parser has taken a byte.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg && !step) |=> !out_valid_reg)
        else $error("verdict appeared without a parser step");

    // Input back-pressure only comes from a full input register behind a stalled verdict.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_in.ready |-> (s1_valid_reg && out_valid_reg && !res_out.ready))
        else $error("input stalled without a held verdict");

endmodule
